### rtl/isll_pkg.sv
// Package of the indexed singly linked list: field widths, request modes,
// status codes, controller states and the allocator control struct.
// Depends on nothing; every other file of the block but isll_ram imports it.
`default_nettype none

package isll_pkg;

  localparam int VAL_W        = 32;
  localparam int POS_W        = 11;
  localparam int CNT_OUT_W    = 11;
  localparam int MODE_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int DEF_CAPACITY = 1024;

  localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FRONT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BACK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AT     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_INS_NEW,
    S_INS_LINK,
    S_DEL_HEAD,
    S_DEL_LINK,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    OP_READ,
    OP_INS_HEAD,
    OP_INS_MID,
    OP_DEL_HEAD,
    OP_DEL_MID
  } op_e;

  typedef struct packed {
    logic prep;
    logic take;
    logic give;
  } alloc_ctl_t;

endpackage

`default_nettype wire

### rtl/isll_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the slot entries and for the freed-slot stack; depends on nothing.
`default_nettype none

module isll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/isll_alloc.sv
// Slot allocator: a stack of freed slots in RAM and a counter of fresh slots.
// Depends on isll_pkg and isll_ram.
`default_nettype none

module isll_alloc
  import isll_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int SW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire alloc_ctl_t    ctl_i,
  input  wire logic [SW-1:0] give_slot_i,
  output logic      [SW-1:0] new_slot_o
);

  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [CW-1:0] top_q, top_d;
  logic [CW-1:0] fresh_q, fresh_d;
  logic [CW-1:0] top_m1;
  logic [SW-1:0] stack_rdata;
  logic          stack_we;

  assign top_m1   = top_q - CW'(1);
  assign stack_we = ctl_i.give && (top_q < CAP_CNT);

  isll_ram #(
    .WIDTH(SW),
    .DEPTH(CAPACITY)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stack_we),
    .waddr_i(top_q[SW-1:0]),
    .wdata_i(give_slot_i),
    .re_i   (ctl_i.prep),
    .raddr_i(top_m1[SW-1:0]),
    .rdata_o(stack_rdata)
  );

  assign new_slot_o = (top_q != '0) ? stack_rdata : fresh_q[SW-1:0];

  always_comb begin
    top_d   = top_q;
    fresh_d = fresh_q;
    if (ctl_i.take) begin
      if (top_q != '0) begin
        top_d = top_m1;
      end else begin
        fresh_d = fresh_q + CW'(1);
      end
    end else if (stack_we) begin
      top_d = top_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q   <= '0;
      fresh_q <= '0;
    end else begin
      top_q   <= top_d;
      fresh_q <= fresh_d;
    end
  end

endmodule

`default_nettype wire

### rtl/indexed_singly_linked_list_top.sv
// Indexed singly linked list: a request controller that walks the slot links
// held in one entry RAM, plus the slot allocator.
// Depends on isll_pkg, isll_ram and isll_alloc.
//
// A request is taken when start_i is high and busy_o is low; busy_o stays high
// until its single result has been shown for one cycle with done_o high, and
// the result cannot be held off. Reads, deletes and inserts take longer the
// further along the list their position lies, since the walk follows one link
// per cycle through the entry RAM's read port; the longest request is an insert
// at the back of a list one short of full. Front inserts need no walk; rejected
// requests, inserts into a full list and read misses need no walk either. The
// next request can be taken in the cycle after done_o. The memories need no
// clearing after reset, so requests are taken at once.
`default_nettype none

module indexed_singly_linked_list_top
  import isll_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic        [MODE_W-1:0]   mode_i,
  input  wire logic        [POS_W-1:0]    list_position_i,
  input  wire logic signed [VAL_W-1:0]    item_value_i,
  output logic                            done_o,
  output logic signed      [VAL_W-1:0]    read_value_o,
  output logic                            found_o,
  output logic             [STATUS_W-1:0] status_o,
  output logic             [CNT_OUT_W-1:0] item_count_o
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int EW = VAL_W + SW;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  state_e state_q, state_d;
  op_e    op_q;

  logic [SW-1:0]    first_slot_q;
  logic [CW-1:0]    count_q;
  logic [SW-1:0]    cur_slot_q;
  logic [SW-1:0]    remain_q;
  logic [EW-1:0]    ent_q;
  logic [SW-1:0]    ns_q;
  logic [VAL_W-1:0] val_q;
  logic [VAL_W-1:0] rv_q;
  logic             found_q;
  logic [STATUS_W-1:0] status_q;

  logic [EW-1:0] rdata;
  logic [SW-1:0] rd_link;
  logic [SW-1:0] ent_link;
  logic [VAL_W-1:0] ent_val;
  logic [VAL_W-1:0] rd_val;
  logic [SW-1:0] new_slot;

  logic          accept;
  logic          walk_end;
  logic          ram_re, ram_we;
  logic [SW-1:0] ram_raddr, ram_waddr;
  logic [EW-1:0] ram_wdata;
  alloc_ctl_t    alloc_ctl;
  logic [SW-1:0] give_slot;

  logic [XW-1:0] posx, cntx, atx, atm1, posm1;
  logic          dec_walk;
  logic          dec_prep;
  op_e           dec_op;
  logic [SW-1:0] dec_steps;
  logic [VAL_W-1:0] dec_rv;
  logic [STATUS_W-1:0] dec_status;
  state_e        dec_state;

  assign rd_link  = rdata[SW-1:0];
  assign rd_val   = rdata[EW-1:SW];
  assign ent_link = ent_q[SW-1:0];
  assign ent_val  = ent_q[EW-1:SW];

  assign accept   = (state_q == S_IDLE) && start_i;
  assign walk_end = (state_q == S_WALK) && (remain_q == '0);

  isll_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  isll_alloc #(
    .CAPACITY(CAPACITY),
    .SW      (SW),
    .CW      (CW)
  ) u_alloc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (alloc_ctl),
    .give_slot_i(give_slot),
    .new_slot_o (new_slot)
  );

  always_comb begin
    posx  = XW'(list_position_i);
    cntx  = XW'(count_q);
    case (mode_i)
      MODE_FRONT: atx = '0;
      MODE_BACK:  atx = cntx;
      default:    atx = posx;
    endcase
    atm1  = atx - XW'(1);
    posm1 = posx - XW'(1);

    dec_walk   = 1'b0;
    dec_prep   = 1'b0;
    dec_op     = OP_READ;
    dec_steps  = '0;
    dec_rv     = '0;
    dec_status = STATUS_DONE;
    case (mode_i)
      MODE_READ: begin
        if (posx < cntx) begin
          dec_walk  = 1'b1;
          dec_steps = posx[SW-1:0];
        end else begin
          dec_rv = '1;
        end
      end
      MODE_FRONT, MODE_BACK, MODE_AT: begin
        if (atx > cntx) begin
          dec_status = STATUS_REJECTED;
        end else if (count_q >= CAP_CNT) begin
          dec_status = STATUS_FULL;
        end else if (atx == '0) begin
          dec_prep = 1'b1;
          dec_op   = OP_INS_HEAD;
        end else begin
          dec_prep  = 1'b1;
          dec_walk  = 1'b1;
          dec_op    = OP_INS_MID;
          dec_steps = atm1[SW-1:0];
        end
      end
      MODE_DELETE: begin
        if (posx >= cntx) begin
          dec_status = STATUS_REJECTED;
        end else if (posx == '0) begin
          dec_walk = 1'b1;
          dec_op   = OP_DEL_HEAD;
        end else begin
          dec_walk  = 1'b1;
          dec_op    = OP_DEL_MID;
          dec_steps = posm1[SW-1:0];
        end
      end
      default: begin
        dec_status = STATUS_REJECTED;
      end
    endcase

    if (dec_walk) begin
      dec_state = S_WALK;
    end else if (dec_op == OP_INS_HEAD && dec_prep) begin
      dec_state = S_INS_NEW;
    end else begin
      dec_state = S_RESP;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = dec_state;
        end
      end
      S_WALK: begin
        if (remain_q == '0) begin
          case (op_q)
            OP_INS_MID:  state_d = S_INS_NEW;
            OP_DEL_HEAD: state_d = S_DEL_HEAD;
            OP_DEL_MID:  state_d = S_DEL_LINK;
            default:     state_d = S_RESP;
          endcase
        end
      end
      S_INS_NEW: begin
        state_d = (op_q == OP_INS_HEAD) ? S_RESP : S_INS_LINK;
      end
      S_INS_LINK: state_d = S_RESP;
      S_DEL_HEAD: state_d = S_RESP;
      S_DEL_LINK: state_d = S_RESP;
      S_RESP:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ram_re         = 1'b0;
    ram_raddr      = first_slot_q;
    ram_we         = 1'b0;
    ram_waddr      = cur_slot_q;
    ram_wdata      = {ent_val, ns_q};
    alloc_ctl.prep = 1'b0;
    alloc_ctl.take = 1'b0;
    alloc_ctl.give = 1'b0;
    give_slot      = cur_slot_q;
    case (state_q)
      S_IDLE: begin
        ram_re         = accept && dec_walk;
        alloc_ctl.prep = accept && dec_prep;
      end
      S_WALK: begin
        ram_raddr = rd_link;
        ram_re    = (remain_q != '0) || (op_q == OP_DEL_MID);
      end
      S_INS_NEW: begin
        ram_we         = 1'b1;
        ram_waddr      = new_slot;
        ram_wdata      = {val_q, (op_q == OP_INS_HEAD) ? first_slot_q : ent_link};
        alloc_ctl.take = 1'b1;
      end
      S_INS_LINK: begin
        ram_we = 1'b1;
      end
      S_DEL_HEAD: begin
        alloc_ctl.give = 1'b1;
      end
      S_DEL_LINK: begin
        ram_we         = 1'b1;
        ram_wdata      = {ent_val, rd_link};
        alloc_ctl.give = 1'b1;
        give_slot      = ent_link;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_READ;
      first_slot_q <= '0;
      count_q      <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        op_q <= dec_op;
      end
      case (state_q)
        S_INS_NEW: begin
          count_q <= count_q + CW'(1);
          if (op_q == OP_INS_HEAD) begin
            first_slot_q <= new_slot;
          end
        end
        S_DEL_HEAD: begin
          count_q      <= count_q - CW'(1);
          first_slot_q <= ent_link;
        end
        S_DEL_LINK: begin
          count_q <= count_q - CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_slot_q <= first_slot_q;
      remain_q   <= dec_steps;
      val_q      <= item_value_i;
      rv_q       <= dec_rv;
      found_q    <= 1'b0;
      status_q   <= dec_status;
    end
    if (state_q == S_WALK && remain_q != '0) begin
      cur_slot_q <= rd_link;
      remain_q   <= remain_q - SW'(1);
    end
    if (walk_end) begin
      ent_q <= rdata;
      if (op_q == OP_READ) begin
        rv_q    <= rd_val;
        found_q <= 1'b1;
      end
    end
    if (state_q == S_INS_NEW) begin
      ns_q <= new_slot;
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = (state_q == S_RESP);
  assign read_value_o = rv_q;
  assign found_o      = found_q;
  assign status_o     = status_q;
  assign item_count_o = CNT_OUT_W'(count_q);

endmodule

`default_nettype wire

### tb/isll_reply_checker.sv
// Reply checker for the indexed singly linked list: it watches the request and
// result transfers, keeps a shadow copy of the list and compares every result.
// Depends on isll_pkg for widths, request modes and status codes.
module isll_reply_checker
  import isll_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic                        busy_o,
  input  wire logic        [MODE_W-1:0]    mode_i,
  input  wire logic        [POS_W-1:0]     list_position_i,
  input  wire logic signed [VAL_W-1:0]     item_value_i,
  input  wire logic                        done_o,
  input  wire logic signed [VAL_W-1:0]     read_value_o,
  input  wire logic                        found_o,
  input  wire logic        [STATUS_W-1:0]  status_o,
  input  wire logic        [CNT_OUT_W-1:0] item_count_o,
  output int                               failures_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VAL_W-1:0]     read_value;
    logic                        found;
    logic        [STATUS_W-1:0]  status;
    logic        [CNT_OUT_W-1:0] item_count;
  } list_reply_t;

  logic signed [VAL_W-1:0] shadow_list[$];
  list_reply_t             expected_replies[$];
  list_reply_t             oldest_reply;

  function automatic list_reply_t predict_reply(input logic [MODE_W-1:0] mode,
                                                input logic [POS_W-1:0] pos,
                                                input logic signed [VAL_W-1:0] value);
    list_reply_t reply;
    int unsigned len;
    int unsigned at;
    reply = '0;
    reply.status = STATUS_DONE;
    len = shadow_list.size();
    case (mode)
      MODE_READ: begin
        if (pos < len) begin
          reply.read_value = shadow_list[pos];
          reply.found = 1'b1;
        end else begin
          reply.read_value = '1;
        end
      end
      MODE_FRONT, MODE_BACK, MODE_AT: begin
        at = (mode == MODE_FRONT) ? 0 : (mode == MODE_BACK) ? len : pos;
        if (at > len) begin
          reply.status = STATUS_REJECTED;
        end else if (len >= CAPACITY) begin
          reply.status = STATUS_FULL;
        end else begin
          shadow_list.insert(at, value);
        end
      end
      MODE_DELETE: begin
        if (pos >= len) begin
          reply.status = STATUS_REJECTED;
        end else begin
          shadow_list.delete(pos);
        end
      end
      default: begin
        reply.status = STATUS_REJECTED;
      end
    endcase
    reply.item_count = CNT_OUT_W'(shadow_list.size());
    return reply;
  endfunction

  task automatic compare_field(input string field, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
    if (got !== want) begin
      failures_o++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_list.delete();
      expected_replies.delete();
      failures_o = 0;
      pending_o = 0;
    end else begin
      if (done_o === 1'b1) begin
        if (expected_replies.size() == 0) begin
          failures_o++;
          $display("%0t ns: result transfer with no request outstanding, actual value %h",
                   $time, read_value_o);
        end else begin
          oldest_reply = expected_replies.pop_front();
          compare_field("read_value", oldest_reply.read_value, read_value_o);
          compare_field("found", VAL_W'(oldest_reply.found), VAL_W'(found_o));
          compare_field("status", VAL_W'(oldest_reply.status), VAL_W'(status_o));
          compare_field("item_count", VAL_W'(oldest_reply.item_count), VAL_W'(item_count_o));
        end
      end
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        expected_replies.push_back(predict_reply(mode_i, list_position_i, item_value_i));
      end
      pending_o = expected_replies.size();
    end
  end

endmodule

### tb/testbench.sv
// Top of the indexed singly linked list testbench: clock, reset and request
// stimulus, with the verdict taken from the reply checker.
// Depends on isll_pkg, isll_reply_checker and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import isll_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam int RANDOM_PER_PHASE = 185;
  localparam logic signed [VAL_W-1:0] VALUE_MIN = {1'b1, {(VAL_W - 1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VALUE_MAX = {1'b0, {(VAL_W - 1){1'b1}}};

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic        [MODE_W-1:0]    mode_i;
  logic        [POS_W-1:0]     list_position_i;
  logic signed [VAL_W-1:0]     item_value_i;
  logic                        done_o;
  logic signed [VAL_W-1:0]     read_value_o;
  logic                        found_o;
  logic        [STATUS_W-1:0]  status_o;
  logic        [CNT_OUT_W-1:0] item_count_o;
  int                          failures;
  int                          pending;

  int idle_pct;
  int list_len;

  indexed_singly_linked_list_top #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .list_position_i(list_position_i),
    .item_value_i   (item_value_i),
    .done_o         (done_o),
    .read_value_o   (read_value_o),
    .found_o        (found_o),
    .status_o       (status_o),
    .item_count_o   (item_count_o)
  );

  isll_reply_checker #(
    .CAPACITY(CAPACITY)
  ) reply_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .list_position_i(list_position_i),
    .item_value_i   (item_value_i),
    .done_o         (done_o),
    .read_value_o   (read_value_o),
    .found_o        (found_o),
    .status_o       (status_o),
    .item_count_o   (item_count_o),
    .failures_o     (failures),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("FAIL indexed_singly_linked_list_top");
    $finish;
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return VALUE_MIN;
      1: return VALUE_MAX;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // The list length is tracked here only to choose positions, in range or past the end, and to steer list growth.
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                              input logic signed [VAL_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    mode_i <= mode;
    list_position_i <= pos;
    item_value_i <= value;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    case (mode)
      MODE_FRONT, MODE_BACK, MODE_AT: begin
        if ((mode != MODE_AT || pos <= list_len) && list_len < CAPACITY) list_len++;
      end
      MODE_DELETE: begin
        if (pos < list_len) list_len--;
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_random_request();
    int unsigned roll;
    int unsigned grow_pct;
    int unsigned lowest;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0] pos;
    roll = $urandom_range(99);
    pos = POS_W'($urandom);
    if (roll < 6) begin
      mode = MODE_W'($urandom_range(int'(MODE_DELETE) + 1, (1 << MODE_W) - 1));
    end else if (roll < 12) begin
      mode = (roll < 8) ? MODE_READ : (roll < 10) ? MODE_AT : MODE_DELETE;
      lowest = (mode == MODE_AT) ? list_len + 1 : list_len;
      pos = POS_W'($urandom_range(lowest, (1 << POS_W) - 1));
    end else begin
      grow_pct = (list_len < 8) ? 70 : (list_len > 48) ? 25 : 45;
      if ($urandom_range(99) < grow_pct || list_len == 0) begin
        case ($urandom_range(2))
          0: mode = MODE_FRONT;
          1: mode = MODE_BACK;
          default: mode = MODE_AT;
        endcase
        if (mode == MODE_AT) pos = POS_W'($urandom_range(0, list_len));
      end else begin
        mode = $urandom_range(1) ? MODE_READ : MODE_DELETE;
        pos = POS_W'($urandom_range(0, list_len - 1));
      end
    end
    send_request(mode, pos, pick_value());
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i <= 1'b0;
    mode_i <= MODE_READ;
    list_position_i <= '0;
    item_value_i <= '0;
    idle_pct = 0;
    list_len = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(MODE_READ, 0, '0);
    send_request(MODE_DELETE, 0, '0);
    send_request(MODE_AT, 1, VALUE_MAX);
    send_request(MODE_AT, 0, VALUE_MAX);
    send_request(MODE_FRONT, 0, VALUE_MIN);
    send_request(MODE_BACK, 0, '0);
    send_request(MODE_BACK, 0, '1);
    send_request(MODE_AT, 2, 32'sh5555_5555);
    send_request(MODE_AT, 5, 32'shAAAA_AAAA);
    send_request(MODE_AT, 7, '1);
    send_request(MODE_READ, 0, '0);
    send_request(MODE_READ, 5, '0);
    send_request(MODE_READ, 6, '0);
    send_request(MODE_READ, '1, '1);
    for (int m = int'(MODE_DELETE) + 1; m < (1 << MODE_W); m++) begin
      send_request(MODE_W'(m), '1, '1);
    end
    send_request(MODE_DELETE, 6, '0);
    send_request(MODE_DELETE, 5, '0);
    send_request(MODE_DELETE, 0, '0);
    send_request(MODE_DELETE, 2, '0);
    send_request(MODE_READ, 2, '0);
    send_request(MODE_FRONT, '1, 1);
    send_request(MODE_AT, '1, '1);

    idle_pct = 37;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) send_random_request();
    idle_pct = 48;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) send_random_request();
    idle_pct = 0;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) send_random_request();

    start_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (CAPACITY + 8) @(posedge clk_i);
    if (failures == 0) begin
      $display("PASS indexed_singly_linked_list_top");
    end else begin
      $display("FAIL indexed_singly_linked_list_top");
    end
    $finish;
  end

endmodule
